// ===== hdl/point_light_vertex_shader_assert.svh =====
// assertion macros for the point light vertex shader
// expects clk and rst_n in the scope of use
`ifndef POINT_LIGHT_VERTEX_SHADER_ASSERT_SVH
`define POINT_LIGHT_VERTEX_SHADER_ASSERT_SVH

// same-cycle implication
`define PLVS_ASSERT_IMP(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed: lbl");

// next-cycle implication
`define PLVS_ASSERT_NXT(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed: lbl");

`endif

// ===== hdl/plvs_pkg.sv =====
// types and constants of the point light vertex shader
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package plvs_pkg;
    localparam int POS_W      = 16;
    localparam int RAD_W      = 17;
    localparam int COL_W      = 8;
    localparam int DIST_W     = 25;
    localparam int SQ_W       = 34;
    localparam int RADICAND_W = 50;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_SHADE = 1'b1;

    typedef struct packed {
        logic                    valid;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic [RAD_W-1:0]        rad_in;
        logic [RAD_W-1:0]        rad_out;
        logic [COL_W-1:0]        col_r;
        logic [COL_W-1:0]        col_g;
        logic [COL_W-1:0]        col_b;
    } light_t;

    typedef struct packed {
        logic wr;
        logic shift;
    } cell_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SUM,
        ST_ROOT,
        ST_CMP,
        ST_DIV,
        ST_ACC,
        ST_NEXT
    } plvs_state_t;
endpackage
`default_nettype wire

// ===== hdl/point_light_vertex_shader.sv =====
// a light write is taken while idle and busy stays low; a shade request
// visits each slot: a disabled light is skipped, an enabled one goes through
// the root and the compare, and through the divider only in the falloff band
// the lights rotate one cell per light through a shared root and divide unit
// results are strobed on done for one cycle; the receiver cannot stall
// reset clears all light enables and the sequencer, light data is kept
`timescale 1ns / 1ps
`default_nettype none
module point_light_vertex_shader #(
    parameter int LIGHT_SLOTS          = 16,
    parameter int WEIGHT_FRACTION_BITS = 16
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               start,
    output logic                              busy,
    input  wire                               action,
    input  wire [3:0]                         slot,
    input  wire                               enable,
    input  wire signed [plvs_pkg::POS_W-1:0]  pos_x,
    input  wire signed [plvs_pkg::POS_W-1:0]  pos_y,
    input  wire signed [plvs_pkg::POS_W-1:0]  pos_z,
    input  wire [plvs_pkg::RAD_W-1:0]         radius_inner,
    input  wire [plvs_pkg::RAD_W-1:0]         radius_outer,
    input  wire [plvs_pkg::COL_W-1:0]         color_r,
    input  wire [plvs_pkg::COL_W-1:0]         color_g,
    input  wire [plvs_pkg::COL_W-1:0]         color_b,
    output logic                              done,
    output logic [plvs_pkg::COL_W-1:0]        out_r,
    output logic [plvs_pkg::COL_W-1:0]        out_g,
    output logic [plvs_pkg::COL_W-1:0]        out_b
);
    import plvs_pkg::*;

    localparam int W     = WEIGHT_FRACTION_BITS;
    localparam int SUM_W = W + 16;
    localparam int CNT_W = (LIGHT_SLOTS > 1) ? $clog2(LIGHT_SLOTS) : 1;
    localparam int PRD_W = SUM_W + COL_W;

    plvs_state_t state_reg, state_next;

    light_t     cell_q [LIGHT_SLOTS];
    cell_ctrl_t ctrl   [LIGHT_SLOTS];
    light_t     wr_data;
    light_t     head;

    logic signed [POS_W-1:0] vx_reg, vy_reg, vz_reg;
    logic [COL_W-1:0]        base_r_reg, base_g_reg, base_b_reg;
    logic [SQ_W-1:0]         sqx_reg, sqy_reg, sqz_reg;
    logic [SQ_W-1:0]         sq_sum;
    logic [SUM_W-1:0]        sum_r_reg, sum_g_reg, sum_b_reg;
    logic [W:0]              weight_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    done_reg;
    logic [COL_W-1:0]        out_r_reg, out_g_reg, out_b_reg;

    logic signed [POS_W:0]   dx, dy, dz;
    logic [DIST_W-1:0]       dist_val;
    logic [DIST_W-1:0]       outer256, inner256;
    logic                    root_start, root_done;
    logic                    div_start, div_done;
    logic [W-1:0]            quot;
    logic                    do_write, do_shade, shift_all, finish;
    logic [PRD_W-1:0]        prd_r, prd_g, prd_b;

    assign do_write = start && !busy && (action == ACT_WRITE);
    assign do_shade = start && !busy && (action == ACT_SHADE);

    always_comb
    begin
        wr_data.valid   = enable;
        wr_data.pos_x   = pos_x;
        wr_data.pos_y   = pos_y;
        wr_data.pos_z   = pos_z;
        wr_data.rad_in  = radius_inner;
        wr_data.rad_out = radius_outer;
        wr_data.col_r   = color_r;
        wr_data.col_g   = color_g;
        wr_data.col_b   = color_b;
    end

    genvar gi;
    generate
        for (gi = 0; gi < LIGHT_SLOTS; gi++)
        begin : g_cell
            assign ctrl[gi].wr    = do_write && (32'(slot) == gi);
            assign ctrl[gi].shift = shift_all;
            plvs_light_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (ctrl[gi]),
                .wr_data  (wr_data),
                .shift_in (cell_q[(gi + 1) % LIGHT_SLOTS]),
                .light    (cell_q[gi])
            );
        end
    endgenerate

    assign head = cell_q[0];

    assign dx = {head.pos_x[POS_W-1], head.pos_x} - {vx_reg[POS_W-1], vx_reg};
    assign dy = {head.pos_y[POS_W-1], head.pos_y} - {vy_reg[POS_W-1], vy_reg};
    assign dz = {head.pos_z[POS_W-1], head.pos_z} - {vz_reg[POS_W-1], vz_reg};
    assign sq_sum   = sqx_reg + sqy_reg + sqz_reg;
    assign outer256 = {head.rad_out, 8'h00};
    assign inner256 = {head.rad_in, 8'h00};

    plvs_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand ({sq_sum, 16'h0000}),
        .done     (root_done),
        .root     (dist_val)
    );

    plvs_div #(
        .QW (W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (DIST_W'(outer256 - dist_val)),
        .denom (DIST_W'(outer256 - inner256)),
        .done  (div_done),
        .quot  (quot)
    );

    always_comb
    begin
        state_next = state_reg;
        root_start = 1'b0;
        div_start  = 1'b0;
        shift_all  = 1'b0;
        finish     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (do_shade)
                    state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (head.valid)
                    state_next = ST_SUM;
                else
                    state_next = ST_NEXT;
            end
            ST_SUM:
            begin
                root_start = 1'b1;
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                if (root_done)
                    state_next = ST_CMP;
            end
            ST_CMP:
            begin
                priority if (outer256 <= dist_val)
                    state_next = ST_NEXT;
                else if (dist_val <= inner256)
                    state_next = ST_ACC;
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                    state_next = ST_ACC;
            end
            ST_ACC:
            begin
                state_next = ST_NEXT;
            end
            ST_NEXT:
            begin
                shift_all = 1'b1;
                if (cnt_reg == CNT_W'(LIGHT_SLOTS - 1))
                begin
                    finish     = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                    state_next = ST_LOAD;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= finish;
            if (do_shade)
                cnt_reg <= '0;
            else if (shift_all)
                cnt_reg <= cnt_reg + 1'b1;
        end
    end

    assign prd_r = PRD_W'(base_r_reg) * PRD_W'(sum_r_reg);
    assign prd_g = PRD_W'(base_g_reg) * PRD_W'(sum_g_reg);
    assign prd_b = PRD_W'(base_b_reg) * PRD_W'(sum_b_reg);

    always_ff @(posedge clk)
    begin
        if (do_shade)
        begin
            vx_reg     <= pos_x;
            vy_reg     <= pos_y;
            vz_reg     <= pos_z;
            base_r_reg <= color_r;
            base_g_reg <= color_g;
            base_b_reg <= color_b;
            sum_r_reg  <= '0;
            sum_g_reg  <= '0;
            sum_b_reg  <= '0;
        end
        if (state_reg == ST_LOAD)
        begin
            sqx_reg <= SQ_W'(dx * dx);
            sqy_reg <= SQ_W'(dy * dy);
            sqz_reg <= SQ_W'(dz * dz);
        end
        if (state_reg == ST_CMP)
            weight_reg <= (W+1)'(1) << W;
        else if (state_reg == ST_DIV && div_done)
            weight_reg <= {1'b0, quot};
        if (state_reg == ST_ACC)
        begin
            sum_r_reg <= SUM_W'(sum_r_reg + SUM_W'(head.col_r) * SUM_W'(weight_reg));
            sum_g_reg <= SUM_W'(sum_g_reg + SUM_W'(head.col_g) * SUM_W'(weight_reg));
            sum_b_reg <= SUM_W'(sum_b_reg + SUM_W'(head.col_b) * SUM_W'(weight_reg));
        end
        if (finish)
        begin
            out_r_reg <= prd_r[W+8 +: COL_W];
            out_g_reg <= prd_g[W+8 +: COL_W];
            out_b_reg <= prd_b[W+8 +: COL_W];
        end
    end

    assign busy  = (state_reg != ST_IDLE);
    assign done  = done_reg;
    assign out_r = out_r_reg;
    assign out_g = out_g_reg;
    assign out_b = out_b_reg;

`include "point_light_vertex_shader_assert.svh"

    `PLVS_ASSERT_NXT(a_shade_busy, do_shade, busy)
    `PLVS_ASSERT_IMP(a_root_in_state, root_done, state_reg == ST_ROOT)
    `PLVS_ASSERT_IMP(a_div_in_state, div_done, state_reg == ST_DIV)
    `PLVS_ASSERT_NXT(a_single_strobe, done, !done)
endmodule
`default_nettype wire

// ===== hdl/plvs_light_cell.sv =====
// one light slot of the rotating light chain
// depends on plvs_pkg
`timescale 1ns / 1ps
`default_nettype none
module plvs_light_cell (
    input  wire                  clk,
    input  wire                  rst_n,
    input  plvs_pkg::cell_ctrl_t ctrl,
    input  plvs_pkg::light_t     wr_data,
    input  plvs_pkg::light_t     shift_in,
    output plvs_pkg::light_t     light
);
    import plvs_pkg::*;

    logic   valid_reg;
    light_t data_reg;
    light_t data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.shift)
            data_next = shift_in;
        else if (ctrl.wr)
            data_next = wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (ctrl.shift || ctrl.wr)
            valid_reg <= data_next.valid;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_comb
    begin
        light       = data_reg;
        light.valid = valid_reg;
    end
endmodule
`default_nettype wire

// ===== hdl/plvs_isqrt.sv =====
// bit-pair serial integer square root, one result bit per cycle
// depends on plvs_pkg
`timescale 1ns / 1ps
`default_nettype none
module plvs_isqrt (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 start,
    input  wire [plvs_pkg::RADICAND_W-1:0]      radicand,
    output logic                                done,
    output logic [plvs_pkg::DIST_W-1:0]         root
);
    import plvs_pkg::*;

    localparam int REM_W = DIST_W + 1;
    localparam int CNT_W = $clog2(DIST_W);

    logic [RADICAND_W-1:0] x_reg;
    logic [REM_W-1:0]      rem_reg;
    logic [DIST_W-1:0]     root_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  run_reg;
    logic                  done_reg;
    logic [REM_W+1:0]      rem_sh;
    logic [REM_W+1:0]      trial;
    logic                  fits;

    assign rem_sh = {rem_reg, x_reg[RADICAND_W-1 -: 2]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign fits   = rem_sh >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIST_W - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (run_reg)
        begin
            x_reg <= {x_reg[RADICAND_W-3:0], 2'b00};
            if (fits)
            begin
                rem_reg  <= REM_W'(rem_sh - trial);
                root_reg <= {root_reg[DIST_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= REM_W'(rem_sh);
                root_reg <= {root_reg[DIST_W-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;
endmodule
`default_nettype wire

// ===== hdl/plvs_div.sv =====
// restoring divider for the falloff weight, one quotient bit per cycle
// numerator is below denominator, so the quotient has QW fraction bits
`timescale 1ns / 1ps
`default_nettype none
module plvs_div #(
    parameter int QW = 16
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               start,
    input  wire [plvs_pkg::DIST_W-1:0]        numer,
    input  wire [plvs_pkg::DIST_W-1:0]        denom,
    output logic                              done,
    output logic [QW-1:0]                     quot
);
    import plvs_pkg::*;

    localparam int CNT_W = $clog2(QW);

    logic [DIST_W-1:0] rem_reg;
    logic [DIST_W-1:0] den_reg;
    logic [QW-1:0]     quot_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              run_reg;
    logic              done_reg;
    logic [DIST_W:0]   rem_sh;
    logic              fits;

    assign rem_sh = {rem_reg, 1'b0};
    assign fits   = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(QW - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= numer;
            den_reg  <= denom;
            quot_reg <= '0;
        end
        else if (run_reg)
        begin
            if (fits)
                rem_reg <= DIST_W'(rem_sh - {1'b0, den_reg});
            else
                rem_reg <= DIST_W'(rem_sh);
            quot_reg <= {quot_reg[QW-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;
endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// testbench for the point light vertex shader: light table writes and vertex shading
// checked against a predictor of its own; depends on plvs_pkg and point_light_vertex_shader
`timescale 1ns / 1ps
module tb;
    import plvs_pkg::*;

    localparam int SLOTS = 16;
    localparam int WFB = 16;
    localparam longint CYCLE_LIMIT = 4000000;

    typedef struct {
        logic [COL_W-1:0] r;
        logic [COL_W-1:0] g;
        logic [COL_W-1:0] b;
    } rgb_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic action = ACT_WRITE;
    logic [3:0] slot = '0;
    logic enable = 1'b0;
    logic signed [POS_W-1:0] pos_x = '0;
    logic signed [POS_W-1:0] pos_y = '0;
    logic signed [POS_W-1:0] pos_z = '0;
    logic [RAD_W-1:0] radius_inner = '0;
    logic [RAD_W-1:0] radius_outer = '0;
    logic [COL_W-1:0] color_r = '0;
    logic [COL_W-1:0] color_g = '0;
    logic [COL_W-1:0] color_b = '0;
    wire busy;
    wire done;
    wire [COL_W-1:0] out_r;
    wire [COL_W-1:0] out_g;
    wire [COL_W-1:0] out_b;

    light_t light_table [SLOTS];
    rgb_t shaded_q [$];
    int errors = 0;
    longint cycles = 0;
    bit idle_en = 1'b1;

    point_light_vertex_shader #(
        .LIGHT_SLOTS(SLOTS),
        .WEIGHT_FRACTION_BITS(WFB)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .action(action),
        .slot(slot),
        .enable(enable),
        .pos_x(pos_x),
        .pos_y(pos_y),
        .pos_z(pos_z),
        .radius_inner(radius_inner),
        .radius_outer(radius_outer),
        .color_r(color_r),
        .color_g(color_g),
        .color_b(color_b),
        .done(done),
        .out_r(out_r),
        .out_g(out_g),
        .out_b(out_b)
    );

    always #4 clk = ~clk;

    function automatic longint unsigned root_floor(input longint unsigned x);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (x >= res + bitv)
            begin
                x = x - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic rgb_t shade_vertex(input logic signed [POS_W-1:0] x,
                                          input logic signed [POS_W-1:0] y,
                                          input logic signed [POS_W-1:0] z,
                                          input logic [COL_W-1:0] r,
                                          input logic [COL_W-1:0] g,
                                          input logic [COL_W-1:0] b);
        longint signed dx, dy, dz;
        longint unsigned sq, dist_val, inner, outer, weight;
        longint unsigned sum_r, sum_g, sum_b;
        rgb_t res;
        sum_r = 0;
        sum_g = 0;
        sum_b = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (!light_table[i].valid)
                continue;
            dx = longint'($signed(light_table[i].pos_x)) - longint'(x);
            dy = longint'($signed(light_table[i].pos_y)) - longint'(y);
            dz = longint'($signed(light_table[i].pos_z)) - longint'(z);
            sq = dx * dx + dy * dy + dz * dz;
            dist_val = root_floor(sq << 16);
            inner = longint'(light_table[i].rad_in) << 8;
            outer = longint'(light_table[i].rad_out) << 8;
            if (outer <= dist_val)
                continue;
            if (dist_val <= inner)
                weight = 64'd1 << WFB;
            else
                weight = ((outer - dist_val) << WFB) / (outer - inner);
            sum_r += light_table[i].col_r * weight;
            sum_g += light_table[i].col_g * weight;
            sum_b += light_table[i].col_b * weight;
        end
        res.r = 8'((longint'(r) * sum_r) >> (WFB + 8));
        res.g = 8'((longint'(g) * sum_g) >> (WFB + 8));
        res.b = 8'((longint'(b) * sum_b) >> (WFB + 8));
        return res;
    endfunction

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    task automatic send(input logic act, input logic [3:0] s, input logic en,
                        input logic signed [POS_W-1:0] x,
                        input logic signed [POS_W-1:0] y,
                        input logic signed [POS_W-1:0] z,
                        input logic [RAD_W-1:0] ri, input logic [RAD_W-1:0] ro,
                        input logic [COL_W-1:0] r, input logic [COL_W-1:0] g,
                        input logic [COL_W-1:0] b);
        if (idle_en && $urandom_range(0, 99) < 13)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        start <= 1'b1;
        action <= act;
        slot <= s;
        enable <= en;
        pos_x <= x;
        pos_y <= y;
        pos_z <= z;
        radius_inner <= ri;
        radius_outer <= ro;
        color_r <= r;
        color_g <= g;
        color_b <= b;
        @(posedge clk iff !busy);
        if (act == ACT_WRITE)
        begin
            light_table[s].valid = en;
            light_table[s].pos_x = x;
            light_table[s].pos_y = y;
            light_table[s].pos_z = z;
            light_table[s].rad_in = ri;
            light_table[s].rad_out = ro;
            light_table[s].col_r = r;
            light_table[s].col_g = g;
            light_table[s].col_b = b;
        end
        else
            shaded_q.push_back(shade_vertex(x, y, z, r, g, b));
    endtask

    task automatic write_light(input int s, input logic en,
                               input int x, input int y, input int z,
                               input int ri, input int ro, input int r, input int g,
                               input int b);
        send(ACT_WRITE, 4'(s), en, POS_W'(x), POS_W'(y), POS_W'(z),
             RAD_W'(ri), RAD_W'(ro), COL_W'(r), COL_W'(g), COL_W'(b));
    endtask

    task automatic shade(input int x, input int y, input int z,
                         input int r, input int g, input int b);
        send(ACT_SHADE, 4'($urandom), 1'($urandom), POS_W'(x), POS_W'(y), POS_W'(z),
             RAD_W'($urandom), RAD_W'($urandom), COL_W'(r), COL_W'(g), COL_W'(b));
    endtask

    task automatic clear_table;
        for (int i = 0; i < SLOTS; i++)
            write_light(i, 1'b0, 0, 0, 0, 0, 0, 0, 0, 0);
    endtask

    task automatic test_empty_table;
        shade(0, 0, 0, 255, 255, 255);
        shade(-32768, 32767, 0, 128, 1, 0);
    endtask

    task automatic test_full_light_and_wrap;
        write_light(0, 1'b1, 0, 0, 0, 100, 200, 255, 255, 255);
        shade(0, 0, 0, 255, 255, 255);
        write_light(1, 1'b1, 10, 10, 10, 100, 200, 255, 128, 1);
        shade(5, 5, 5, 255, 200, 255);
    endtask

    task automatic test_falloff_band;
        clear_table();
        write_light(2, 1'b1, 0, 0, 0, 10, 100, 200, 100, 50);
        shade(50, 0, 0, 255, 255, 255);
        shade(30, 40, 20, 200, 255, 90);
        shade(0, 0, 99, 255, 255, 255);
        shade(0, 0, 100, 255, 255, 255);
        shade(0, 0, 10, 255, 255, 255);
    endtask

    task automatic test_inverted_radii;
        write_light(3, 1'b1, 0, 0, 0, 80, 40, 90, 180, 255);
        shade(0, 0, 39, 255, 255, 255);
        shade(0, 0, 40, 255, 255, 255);
        write_light(3, 1'b1, 0, 0, 0, 0, 0, 90, 180, 255);
        shade(0, 0, 0, 255, 255, 255);
    endtask

    task automatic test_disabled_slot;
        write_light(4, 1'b0, 0, 0, 0, 100, 100, 255, 255, 255);
        shade(0, 0, 0, 255, 255, 255);
    endtask

    task automatic test_extremes;
        clear_table();
        write_light(15, 1'b1, -32768, -32768, -32768, 131071, 131071, 255, 255, 255);
        write_light(0, 1'b1, 32767, 32767, 32767, 0, 131071, 255, 255, 255);
        shade(32767, 32767, 32767, 255, 255, 255);
        shade(0, 0, 0, 255, 255, 255);
    endtask

    function automatic int rand_coord(input bit wide);
        if (wide)
            return $signed(16'($urandom));
        return $urandom_range(0, 600) - 300;
    endfunction

    task automatic test_random;
        bit wide;
        for (int n = 0; n < 950; n++)
        begin
            idle_en = !(n >= 300 && n < 500);
            wide = $urandom_range(0, 99) < 15;
            if ($urandom_range(0, 99) < 35)
            begin
                if (wide)
                    write_light(4'($urandom), 1'($urandom), rand_coord(1), rand_coord(1),
                                rand_coord(1), $urandom_range(0, 131071),
                                $urandom_range(0, 131071), $urandom_range(0, 255),
                                $urandom_range(0, 255), $urandom_range(0, 255));
                else
                    write_light(4'($urandom), $urandom_range(0, 99) < 80, rand_coord(0),
                                rand_coord(0), rand_coord(0), $urandom_range(0, 250),
                                $urandom_range(0, 600), $urandom_range(0, 255),
                                $urandom_range(0, 255), $urandom_range(0, 255));
            end
            else
                shade(rand_coord(wide), rand_coord(wide), rand_coord(wide),
                      $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
        end
        idle_en = 1'b1;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            rgb_t want;
            cycles++;
            if (done)
            begin
                if (shaded_q.size() == 0)
                    report("unexpected result", out_r, 0);
                else
                begin
                    want = shaded_q.pop_front();
                    if (out_r !== want.r)
                        report("out_r", out_r, want.r);
                    if (out_g !== want.g)
                        report("out_g", out_g, want.g);
                    if (out_b !== want.b)
                        report("out_b", out_b, want.b);
                end
            end
            if (cycles > CYCLE_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        for (int i = 0; i < SLOTS; i++)
            light_table[i] = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_table();
        test_full_light_and_wrap();
        test_falloff_band();
        test_inverted_radii();
        test_disabled_slot();
        test_extremes();
        test_random();
        start <= 1'b0;
        while (shaded_q.size() != 0)
            @(posedge clk);
        repeat (1000) @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
